>>> hw/rtl/fqd_pkg.sv
// Shared types and constants of the key queue with delete.
`default_nettype none

package fqd_pkg;

    localparam int FQD_DEPTH     = 16;
    localparam int FQD_KEY_WIDTH = 32;
    localparam int KEY_PORT_W    = 32;
    localparam int LEN_W         = 5;

    typedef enum logic [1:0] {
        MODE_ENQ  = 2'd0,
        MODE_DEQ  = 2'd1,
        MODE_DEL  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NULL      = 2'd1,
        ST_FULLEMPTY = 2'd2,
        ST_NOTFOUND  = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    match;
        logic    scan;
        logic    apply;
        logic    do_enq;
        logic    do_deq;
        logic    do_del;
        t_status status;
    } t_dp_cmd;

    // Conditions reported by the datapath to the controller.
    typedef struct packed {
        logic key_zero;
        logic full;
        logic empty;
        logic found;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hw/rtl/fqd_ctrl.sv
// Controller state machine of the key queue: sequences each item and holds the result valid.
`default_nettype none

module fqd_ctrl import fqd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire logic [1:0] i_mode,
    output logic          o_valid,
    input  wire logic     i_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_SCAN,
        S_APPLY
    } t_state;

    t_state r_state;
    t_mode  r_mode;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_slot_free;
    logic   w_load;
    t_status w_status;
    logic   w_enq, w_deq, w_del;

    assign w_accept    = (r_state == S_IDLE) && i_valid;
    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_load      = (r_state == S_APPLY) && w_slot_free;

    always_comb begin
        w_status = ST_OK;
        w_enq    = 1'b0;
        w_deq    = 1'b0;
        w_del    = 1'b0;
        unique case (r_mode)
            MODE_ENQ: begin
                if (i_stat.key_zero) begin
                    w_status = ST_NULL;
                end else if (i_stat.full) begin
                    w_status = ST_FULLEMPTY;
                end else begin
                    w_enq = 1'b1;
                end
            end
            MODE_DEQ: begin
                if (i_stat.empty) begin
                    w_status = ST_FULLEMPTY;
                end else begin
                    w_deq = 1'b1;
                end
            end
            MODE_DEL: begin
                if (i_stat.key_zero) begin
                    w_status = ST_NULL;
                end else if (!i_stat.found) begin
                    w_status = ST_NOTFOUND;
                end else begin
                    w_del = 1'b1;
                end
            end
            MODE_NONE: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode  <= t_mode'(i_mode);
                        // Only a delete needs the match and scan passes.
                        r_state <= (t_mode'(i_mode) == MODE_DEL) ? S_MATCH : S_APPLY;
                    end
                end
                S_MATCH: r_state <= S_SCAN;
                S_SCAN:  r_state <= S_APPLY;
                S_APPLY: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_cmd.capture  = w_accept;
    assign o_cmd.match    = (r_state == S_MATCH);
    assign o_cmd.scan     = (r_state == S_SCAN);
    assign o_cmd.apply    = w_load;
    assign o_cmd.do_enq   = w_enq;
    assign o_cmd.do_deq   = w_deq;
    assign o_cmd.do_del   = w_del;
    assign o_cmd.status   = w_status;

endmodule

`default_nettype wire

>>> hw/rtl/fqd_datapath.sv
// Datapath of the key queue: entry cells, parallel match, first-match scan and result registers.
`default_nettype none

module fqd_datapath import fqd_pkg::*; #(
    parameter int DEPTH     = FQD_DEPTH,
    parameter int KEY_WIDTH = FQD_KEY_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [KEY_PORT_W-1:0] i_key,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic [1:0]                 o_status,
    output logic [KEY_PORT_W-1:0]      o_key_out,
    output logic [LEN_W-1:0]           o_length
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int KW_IN = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
    localparam int LVL   = $clog2(DEPTH);

    logic [KEY_WIDTH-1:0]  r_cell [DEPTH];
    logic [KEY_WIDTH-1:0]  r_key;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [DEPTH-1:0]      r_match;
    logic [DEPTH-1:0]      r_kill;
    logic [DEPTH-1:0]      n_kill;
    logic [DEPTH-1:0]      w_shift;
    logic [1:0]            r_status;
    logic [KEY_PORT_W-1:0] r_key_out;
    logic [LEN_W-1:0]      r_length;

    // Parallel prefix OR: every cell from the first match onward takes the key of the cell above it.
    always_comb begin
        n_kill = r_match;
        for (int s = 0; s < LVL; s++) begin
            n_kill = n_kill | (n_kill << (1 << s));
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.do_enq) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.do_deq || i_cmd.do_del) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_shift = i_cmd.do_deq ? {DEPTH{1'b1}} : (i_cmd.do_del ? r_kill : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.apply) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key <= KEY_WIDTH'(i_key[KW_IN-1:0]);
        end
        if (i_cmd.match) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_match[i] <= (r_cell[i] == r_key) && (CW'(i) < r_count);
            end
        end
        if (i_cmd.scan) begin
            r_kill <= n_kill;
        end
        if (i_cmd.apply) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (w_shift[i]) begin
                    r_cell[i] <= r_cell[i + 1];
                end else if (i_cmd.do_enq && (CW'(i) == r_count)) begin
                    r_cell[i] <= r_key;
                end
            end
            if (i_cmd.do_enq && (CW'(DEPTH - 1) == r_count)) begin
                r_cell[DEPTH - 1] <= r_key;
            end
            r_status  <= i_cmd.status;
            r_key_out <= i_cmd.do_deq ? KEY_PORT_W'(r_cell[0][KW_IN-1:0]) : '0;
            r_length  <= LEN_W'(n_count);
        end
    end

    assign o_stat.key_zero = (r_key == '0);
    assign o_stat.full     = (r_count >= CW'(DEPTH));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.found    = |r_match;
    assign o_status        = r_status;
    assign o_key_out       = r_key_out;
    assign o_length        = r_length;

endmodule

`default_nettype wire

>>> hw/rtl/fifo_queue_with_delete_core.sv
// Top level of the key queue with enqueue, dequeue and delete of the oldest matching key.
`default_nettype none

// A first-in first-out queue of DEPTH non-zero keys. One item is worked on at a time. Enqueue,
// dequeue and the unused mode go from acceptance straight to the apply state. A delete first
// passes through a registered compare of every entry and then a registered first-match scan
// before it reaches the apply state. Only then do the entries above the match move down by one.
// In the apply state the result is loaded into the output register once the output is free to
// take it, and the next item can be taken once the controller is back in idle after the load.
// Input stall is high from acceptance until the result is loaded into the output register. That
// register holds the result while the output is stalled. Entries need no clearing after reset;
// the length is reported modulo 32.
module fifo_queue_with_delete_core import fqd_pkg::*; #(
    parameter int DEPTH     = FQD_DEPTH,
    parameter int KEY_WIDTH = FQD_KEY_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [1:0]            i_mode,
    input  wire logic [KEY_PORT_W-1:0] i_key,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [1:0]                 o_status,
    output logic [KEY_PORT_W-1:0]      o_key_out,
    output logic [LEN_W-1:0]           o_length
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    fqd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_mode  (i_mode),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    fqd_datapath #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (i_key),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_status  (o_status),
        .o_key_out (o_key_out),
        .o_length  (o_length)
    );

`ifndef SYNTH
    // Once an item is taken, no second one may enter before its result is loaded.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted while an item is still in progress");

    // A non-zero key only ever leaves on a successful dequeue.
    a_key_out_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_key_out != '0)) |-> (o_status == ST_OK))
        else $error("key returned with an error status");

    // A result is only loaded in the cycle that ends an item's work.
    a_load_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.apply |=> !o_stall)
        else $error("result loaded while the controller stays busy");
`endif

endmodule

`default_nettype wire
